// ===== rtl/spat_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment and page address translator package
// Shared types, codes and constants for the translator modules.
// ----------------------------------------------------------------------------
package spat_pkg;

    localparam int PAGE_TABLE_DEPTH = 1024;
    localparam int PT_AW            = 10;
    localparam int DESC_PRESENT_BIT = 47;
    localparam int DESC_GRAN_BIT    = 55;

    typedef enum logic [1:0] {
        K_TRANSLATE    = 2'd0,
        K_WRITE_GLOBAL = 2'd1,
        K_WRITE_LOCAL  = 2'd2,
        K_WRITE_PAGE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_NONE   = 3'd0,
        R_NULL   = 3'd1,
        R_RANGE  = 3'd2,
        R_ABSENT = 3'd3,
        R_LIMIT  = 3'd4
    } t_reason;

    typedef struct packed {
        logic clear;
        logic write;
        logic start;
        logic check;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/spat_if.sv =====
// ----------------------------------------------------------------------------
// Translator channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface spat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] selector;
    logic [31:0] offset;
    logic [9:0]  write_index;
    logic [63:0] write_data;

    modport source (output valid, kind, selector, offset, write_index, write_data,
                    input ready);
    modport sink   (input valid, kind, selector, offset, write_index, write_data,
                    output ready);
endinterface

interface spat_out_if;
    logic        valid;
    logic        ready;
    logic        invalid;
    logic [2:0]  fault_reason;
    logic [31:0] physical_address;

    modport source (output valid, invalid, fault_reason, physical_address,
                    input ready);
    modport sink   (input valid, invalid, fault_reason, physical_address,
                    output ready);
endinterface

// ===== rtl/spat_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spat_datapath.sv =====
// ----------------------------------------------------------------------------
// Translator datapath
// Table memories, clearing counter, descriptor checks and the result register.
// ----------------------------------------------------------------------------
module spat_datapath #(
    parameter int DESCRIPTOR_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spat_pkg::t_cmd   i_cmd,
    output spat_pkg::t_sts   o_sts,
    input  spat_pkg::t_kind  i_kind,
    input  logic [15:0]      i_selector,
    input  logic [31:0]      i_offset,
    input  logic [9:0]       i_write_index,
    input  logic [63:0]      i_write_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_invalid,
    output logic [2:0]       o_fault_reason,
    output logic [31:0]      o_physical_address
);

    import spat_pkg::*;

    localparam int DI_AW     = $clog2(DESCRIPTOR_DEPTH);
    localparam int DT_AW     = DI_AW + 1;
    localparam int DT_DEPTH  = 2 ** DT_AW;
    localparam int CLR_DEPTH = (DT_DEPTH > PAGE_TABLE_DEPTH) ? DT_DEPTH : PAGE_TABLE_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    logic [CLR_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic [31:0]       r_offset;
    t_reason           r_pre_reason;
    t_reason           r_reason;
    logic [11:0]       r_lin_low;
    logic              r_out_valid, n_out_valid;
    logic              r_out_invalid;
    t_reason           r_out_reason;
    logic [31:0]       r_out_phys;

    logic              d_we, d_re;
    logic [DT_AW-1:0]  d_waddr, d_raddr;
    logic [63:0]       d_wdata, d_rdata;
    logic              p_we, p_re;
    logic [PT_AW-1:0]  p_waddr, p_raddr;
    logic [19:0]       p_wdata, p_rdata;

    logic              desc_wr_ok;
    logic [12:0]       sel_index;
    t_reason           pre_reason;
    logic [19:0]       desc_limit;
    logic [31:0]       seg_base;
    logic [31:0]       limit_eff;
    logic [31:0]       lin;
    t_reason           chk_reason;
    logic              res_invalid;

    assign desc_wr_ok = 32'(i_write_index) < 32'(DESCRIPTOR_DEPTH);
    assign sel_index  = i_selector[15:3];

    always_comb begin
        d_we    = 1'b0;
        d_waddr = {(i_kind == K_WRITE_LOCAL), DI_AW'(i_write_index)};
        d_wdata = i_write_data;
        p_we    = 1'b0;
        p_waddr = i_write_index;
        p_wdata = i_write_data[31:12];
        if (i_cmd.clear) begin
            d_we    = 1'b1;
            d_waddr = DT_AW'(r_clr_cnt);
            d_wdata = '0;
            p_we    = 1'b1;
            p_waddr = PT_AW'(r_clr_cnt);
            p_wdata = '0;
        end else if (i_cmd.write) begin
            d_we = ((i_kind == K_WRITE_GLOBAL) || (i_kind == K_WRITE_LOCAL)) && desc_wr_ok;
            p_we = (i_kind == K_WRITE_PAGE);
        end
    end

    assign d_re    = i_cmd.start;
    assign d_raddr = {i_selector[2], DI_AW'(sel_index)};

    always_comb begin
        if (!i_selector[2] && (sel_index == 13'd0)) begin
            pre_reason = R_NULL;
        end else if (32'(sel_index) >= 32'(DESCRIPTOR_DEPTH)) begin
            pre_reason = R_RANGE;
        end else begin
            pre_reason = R_NONE;
        end
    end

    assign desc_limit = {d_rdata[51:48], d_rdata[15:0]};
    assign seg_base   = {d_rdata[63:56], d_rdata[39:16]};
    assign limit_eff  = d_rdata[DESC_GRAN_BIT] ? {desc_limit, 12'h000} : {12'h000, desc_limit};
    assign lin        = seg_base + r_offset;

    always_comb begin
        if (r_pre_reason != R_NONE) begin
            chk_reason = r_pre_reason;
        end else if (!d_rdata[DESC_PRESENT_BIT]) begin
            chk_reason = R_ABSENT;
        end else if (r_offset > limit_eff) begin
            chk_reason = R_LIMIT;
        end else begin
            chk_reason = R_NONE;
        end
    end

    assign p_re    = i_cmd.check;
    assign p_raddr = lin[21:12];

    spat_ram #(.WIDTH(64), .DEPTH(DT_DEPTH)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    spat_ram #(.WIDTH(20), .DEPTH(PAGE_TABLE_DEPTH)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign res_invalid = (r_reason != R_NONE);

    always_comb begin
        n_clr_cnt = r_clr_cnt;
        if (i_cmd.clear) begin
            n_clr_cnt = r_clr_cnt + CLR_AW'(1);
        end
        n_out_valid = r_out_valid;
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_offset     <= i_offset;
            r_pre_reason <= pre_reason;
        end
        if (i_cmd.check) begin
            r_reason  <= chk_reason;
            r_lin_low <= lin[11:0];
        end
        if (i_cmd.finish) begin
            r_out_invalid <= res_invalid;
            r_out_reason  <= r_reason;
            r_out_phys    <= res_invalid ? 32'h0 : {p_rdata, r_lin_low};
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_invalid          = r_out_invalid;
    assign o_fault_reason     = r_out_reason;
    assign o_physical_address = r_out_phys;

`ifndef SYNTHESIS
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> o_sts.out_free)
        else $error("Result loaded while the output register is still occupied.");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("Result load did not raise the output valid.");

    a_invalid_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_invalid) |-> (r_out_phys == 32'h0))
        else $error("Faulted transaction carries a nonzero address.");

    a_reason_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_invalid == (r_out_reason != R_NONE)))
        else $error("Fault flag and fault reason disagree.");
`endif

endmodule

// ===== rtl/spat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Translator controller
// State machine that sequences clearing, table writes and translations.
// ----------------------------------------------------------------------------
module spat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  spat_pkg::t_kind i_in_kind,
    input  spat_pkg::t_sts  i_sts,
    output spat_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);

    import spat_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DESC  = 4'b0100,
        ST_PAGE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == K_TRANSLATE) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_DESC;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_DESC: begin
                o_cmd.check = 1'b1;
                n_state     = ST_PAGE;
            end
            ST_PAGE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_check_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> o_cmd.check)
        else $error("Descriptor check did not follow the descriptor read.");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (!o_cmd.start && !o_cmd.write && !o_in_ready))
        else $error("Transaction taken during the clearing pass.");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Controller state is not one-hot.");
`endif

endmodule

// ===== rtl/segment_page_address_translator_unit.sv =====
// ----------------------------------------------------------------------------
// Segment and page address translator
// Descriptor table lookup, segment checks and single-level page translation.
// ----------------------------------------------------------------------------
// After reset the block clears its descriptor and page tables, one entry per
// cycle for the larger of 1024 and twice DESCRIPTOR_DEPTH rounded up to a power
// of two, and accepts no transaction until that pass is done. A table write
// is done as it is accepted. A translation is a descriptor memory read, then
// the limit check and base add that address the page table memory, then the
// page table read that loads the output register once it is free. The two
// reads are dependent, and the block works on one translation at a time.
module segment_page_address_translator_unit #(
    parameter int DESCRIPTOR_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spat_in_if.sink     i_in,
    spat_out_if.source  o_out
);

    import spat_pkg::*;

    t_cmd  cmd;
    t_sts  sts;
    t_kind in_kind;
    logic  in_ready;

    assign in_kind    = t_kind'(i_in.kind);
    assign i_in.ready = in_ready;

    spat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (in_kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    spat_datapath #(.DESCRIPTOR_DEPTH(DESCRIPTOR_DEPTH)) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (in_kind),
        .i_selector         (i_in.selector),
        .i_offset           (i_in.offset),
        .i_write_index      (i_in.write_index),
        .i_write_data       (i_in.write_data),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_invalid          (o_out.invalid),
        .o_fault_reason     (o_out.fault_reason),
        .o_physical_address (o_out.physical_address)
    );

endmodule

// ===== verif/spat_xlat_check_pkg.sv =====
// ----------------------------------------------------------------------------
// Address translation scoreboard
// Keeps a shadow copy of the descriptor and page tables, predicts the outcome
// of every accepted translation and compares it with the response that comes
// back from the block, field by field and in order.
// ----------------------------------------------------------------------------
package spat_xlat_check_pkg;

    import spat_pkg::*;

    localparam int DESC_DEPTH = 256;

    typedef struct {
        logic        invalid;
        t_reason     reason;
        logic [31:0] address;
    } t_xlat_result;

    class translation_checker;

        logic [63:0]  global_desc [DESC_DEPTH];
        logic [63:0]  local_desc [DESC_DEPTH];
        logic [19:0]  frame_of_page [PAGE_TABLE_DEPTH];
        t_xlat_result pending_translations [$];
        int unsigned  mismatches;

        function new();
            foreach (global_desc[i]) global_desc[i] = '0;
            foreach (local_desc[i]) local_desc[i] = '0;
            foreach (frame_of_page[i]) frame_of_page[i] = '0;
            mismatches = 0;
        endfunction

        function logic [63:0] descriptor_at(logic [15:0] sel);
            logic [12:0] idx;
            idx = sel[15:3];
            if ((!sel[2] && idx == 0) || idx >= DESC_DEPTH) begin
                return '0;
            end
            return sel[2] ? local_desc[idx] : global_desc[idx];
        endfunction

        function logic [31:0] segment_limit(logic [63:0] desc);
            if (desc[DESC_GRAN_BIT]) begin
                return {desc[51:48], desc[15:0], 12'd0};
            end
            return {12'd0, desc[51:48], desc[15:0]};
        endfunction

        function t_xlat_result translate_address(logic [15:0] sel, logic [31:0] off);
            t_xlat_result res;
            logic [12:0]  idx;
            logic [63:0]  desc;
            logic [31:0]  linear;
            idx = sel[15:3];
            res.invalid = 1'b1;
            res.address = '0;
            if (!sel[2] && idx == 0) begin
                res.reason = R_NULL;
            end else if (idx >= DESC_DEPTH) begin
                res.reason = R_RANGE;
            end else begin
                desc = descriptor_at(sel);
                if (!desc[DESC_PRESENT_BIT]) begin
                    res.reason = R_ABSENT;
                end else if (off > segment_limit(desc)) begin
                    res.reason = R_LIMIT;
                end else begin
                    linear = {desc[63:56], desc[39:16]} + off;
                    res.invalid = 1'b0;
                    res.reason = R_NONE;
                    res.address = {frame_of_page[linear[21:12]], linear[11:0]};
                end
            end
            return res;
        endfunction

        function void note_request(t_kind kind, logic [15:0] sel, logic [31:0] off,
                                   logic [9:0] widx, logic [63:0] wdata);
            case (kind)
                K_TRANSLATE: begin
                    pending_translations.insert(pending_translations.size(),
                                                translate_address(sel, off));
                end
                K_WRITE_GLOBAL: begin
                    if (widx < DESC_DEPTH) global_desc[widx] = wdata;
                end
                K_WRITE_LOCAL: begin
                    if (widx < DESC_DEPTH) local_desc[widx] = wdata;
                end
                default: begin
                    frame_of_page[widx] = wdata[31:12];
                end
            endcase
        endfunction

        function void check_response(logic invalid, logic [2:0] reason, logic [31:0] pa);
            t_xlat_result exp;
            if (pending_translations.size() == 0) begin
                $error("Response received with no translation outstanding.");
                mismatches++;
                return;
            end
            exp = pending_translations.pop_front();
            if (invalid !== exp.invalid) begin
                $error("invalid: expected %0b, actual %0b", exp.invalid, invalid);
                mismatches++;
            end
            if (reason !== exp.reason) begin
                $error("fault_reason: expected %0d, actual %0d", exp.reason, reason);
                mismatches++;
            end
            if (pa !== exp.address) begin
                $error("physical_address: expected 0x%08h, actual 0x%08h", exp.address, pa);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_translations.size();
        endfunction

    endclass

endpackage

// ===== verif/tb_segment_page_address_translator_unit.sv =====
// ----------------------------------------------------------------------------
// Segment and page address translator testbench
// Drives table writes and translations with random gaps, stalls the response
// channel at random and once for a long stretch, and checks every response
// against a shadow model of the descriptor and page tables.
// ----------------------------------------------------------------------------
module tb_segment_page_address_translator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import spat_pkg::*;
    import spat_xlat_check_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 1500;

    logic i_clk;
    logic i_rst_n;

    spat_in_if  req_ch ();
    spat_out_if rsp_ch ();

    translation_checker xlat_model = new();

    int unsigned idle_cycles = 0;
    int unsigned sent_items  = 0;
    bit          hold_request = 1'b0;

    segment_page_address_translator_unit #(
        .DESCRIPTOR_DEPTH(DESC_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    always begin
        i_clk = 1'b0;
        #5ns;
        i_clk = 1'b1;
        #5ns;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            xlat_model.check_response(rsp_ch.invalid, rsp_ch.fault_reason,
                                      rsp_ch.physical_address);
        end
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall_left;
        int hold_left;
        int unsigned cycle;
        bit hold_taken;
        stall_left = 0;
        hold_left = 0;
        cycle = 0;
        hold_taken = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready = 1'b1;
                if ((cycle / 256) % 4 != 2 && $urandom_range(0, 99) < 25) begin
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                              : $urandom_range(10, 50);
                end
            end
        end
    end

    function automatic logic [63:0] make_desc(logic [31:0] base, logic [19:0] limit,
                                              logic present, logic gran);
        return {base[31:24], gran, 3'b000, limit[19:16], present, 7'd0,
                base[23:0], limit[15:0]};
    endfunction

    task automatic send_item(t_kind kind, logic [15:0] sel, logic [31:0] off,
                             logic [9:0] widx, logic [63:0] wdata);
        int unsigned gap;
        int unsigned r;
        @(negedge i_clk);
        req_ch.valid       = 1'b1;
        req_ch.kind        = kind;
        req_ch.selector    = sel;
        req_ch.offset      = off;
        req_ch.write_index = widx;
        req_ch.write_data  = wdata;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        xlat_model.note_request(kind, sel, off, widx, wdata);
        sent_items++;
        r = $urandom_range(0, 99);
        if ((sent_items / 128) % 4 == 3 || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random_item();
        t_kind       kind;
        logic [15:0] sel;
        logic [31:0] off;
        logic [31:0] lim;
        logic [9:0]  widx;
        logic [63:0] wdata;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            kind = K_TRANSLATE;
        end else if (r < 72) begin
            kind = K_WRITE_GLOBAL;
        end else if (r < 84) begin
            kind = K_WRITE_LOCAL;
        end else begin
            kind = K_WRITE_PAGE;
        end
        wdata = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (kind == K_WRITE_PAGE || r >= 95) begin
            widx = 10'($urandom);
        end else if (r < 80) begin
            widx = 10'($urandom_range(0, 7));
        end else begin
            widx = 10'($urandom_range(0, DESC_DEPTH - 1));
        end
        if (kind != K_WRITE_PAGE && $urandom_range(0, 9) != 0) begin
            wdata[DESC_PRESENT_BIT] = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
            sel = {13'($urandom_range(0, 7)), 3'($urandom)};
        end else begin
            sel = 16'($urandom);
        end
        lim = xlat_model.segment_limit(xlat_model.descriptor_at(sel));
        r = $urandom_range(0, 19);
        if (r < 7) begin
            off = lim - $urandom_range(0, 2);
        end else if (r < 8) begin
            off = lim + 1;
        end else if (r < 14) begin
            off = $urandom_range(0, lim);
        end else if (r < 18) begin
            off = $urandom;
        end else if (r < 19) begin
            off = '0;
        end else begin
            off = '1;
        end
        send_item(kind, sel, off, widx, wdata);
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.kind        = K_TRANSLATE;
        req_ch.selector    = '0;
        req_ch.offset      = '0;
        req_ch.write_index = '0;
        req_ch.write_data  = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(K_TRANSLATE, 16'h0000, 32'h0, 10'd0, 64'd0);
        send_item(K_TRANSLATE, 16'h0003, 32'hFFFF_FFFF, 10'd0, 64'd0);
        send_item(K_TRANSLATE, 16'h0004, 32'h0, 10'd0, 64'd0);
        send_item(K_TRANSLATE, {13'd256, 3'b000}, 32'h0, 10'd0, 64'd0);
        send_item(K_TRANSLATE, 16'hFFFF, 32'h0, 10'd0, 64'd0);
        send_item(K_WRITE_PAGE, 16'h0, 32'h0, 10'd1023, '1);
        send_item(K_WRITE_PAGE, 16'h0, 32'h0, 10'd0, 64'h0000_0000_ABCD_E123);
        send_item(K_WRITE_GLOBAL, 16'h0, 32'h0, 10'd1,
                  make_desc(32'h0, 20'h00FFF, 1'b1, 1'b0));
        send_item(K_TRANSLATE, {13'd1, 3'b011}, 32'h0000_0FFF, 10'd0, 64'd0);
        send_item(K_TRANSLATE, {13'd1, 3'b000}, 32'h0000_1000, 10'd0, 64'd0);
        send_item(K_WRITE_LOCAL, 16'h0, 32'h0, 10'd0,
                  make_desc(32'hFFFF_F000, 20'hFFFFF, 1'b1, 1'b1));
        send_item(K_TRANSLATE, 16'h0004, 32'hFFFF_F000, 10'd0, 64'd0);
        send_item(K_TRANSLATE, 16'h0004, 32'hFFFF_F001, 10'd0, 64'd0);
        send_item(K_TRANSLATE, 16'h0004, 32'hFFFF_FFFF, 10'd0, 64'd0);
        send_item(K_WRITE_GLOBAL, 16'h0, 32'h0, 10'd255, ~(64'd1 << DESC_PRESENT_BIT));
        send_item(K_TRANSLATE, {13'd255, 3'b000}, 32'h0, 10'd0, 64'd0);
        send_item(K_WRITE_GLOBAL, 16'h0, 32'h0, 10'd255, '1);
        send_item(K_TRANSLATE, {13'd255, 3'b000}, 32'h0040_0000, 10'd0, 64'd0);
        send_item(K_WRITE_GLOBAL, 16'h0, 32'h0, 10'd1023, 64'd0);
        send_item(K_WRITE_GLOBAL, 16'h0, 32'h0, 10'd256, 64'd0);
        send_item(K_TRANSLATE, {13'd255, 3'b000}, 32'h0, 10'd0, 64'd0);
        send_item(K_WRITE_LOCAL, 16'h0, 32'h0, 10'd512, 64'd0);
        send_item(K_TRANSLATE, 16'h0004, 32'h0, 10'd0, 64'd0);
        send_item(K_WRITE_PAGE, 16'h0, 32'h0, 10'd512, {$urandom, $urandom});

        hold_request = 1'b1;
        repeat (RANDOM_ITEMS) send_random_item();
        @(negedge i_clk);
        req_ch.valid = 1'b0;

        while (xlat_model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (xlat_model.mismatches == 0 && xlat_model.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== segment_page_address_translator_unit.f =====
rtl/spat_pkg.sv
rtl/spat_if.sv
rtl/spat_ram.sv
rtl/spat_datapath.sv
rtl/spat_ctrl.sv
rtl/segment_page_address_translator_unit.sv
verif/spat_xlat_check_pkg.sv
verif/tb_segment_page_address_translator_unit.sv
